/* src/leat_pkg.sv */
// Shared types, constants and helpers for the live entity aging table.
// No dependencies.
package leat_pkg;

    localparam int ENTITIES_DEFAULT = 16;
    localparam int KEY_W   = 64;
    localparam int TIME_W  = 48;
    localparam int WIN_W   = 32;
    localparam int CNT_W   = 32;
    localparam int RSSI_W  = 8;
    localparam int SLOT_W  = 4;
    localparam int ACT_W   = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_META_WIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RID_WIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SSID_WIN = 2'd2;

    localparam logic [CNT_W-1:0] CNT_SAT = '1;

    typedef struct packed {
        logic start;
        logic step;
        logic finish;
    } leat_cmd_t;

    typedef struct packed {
        logic last;
    } leat_stat_t;

endpackage

/* src/live_entity_aging_table_unit.sv */
// Top level of the live entity aging table: controller plus datapath.
// Depends on leat_pkg, leat_ctrl, leat_datapath.
//
//  channel | handshake            | payload
//  in      | in_valid / in_stall  | req_type entity_key is_meta remote_id_source rssi now_ms
//  out     | out_valid / out_stall| accepted slot_used entry_count peak_rssi active_count
//  cfg     | cfg_we               | cfg_idx cfg_data
//
// Each word is accepted, walked one slot per step over the table, and then
// written back. A finished word sits in the output register while the next
// word is walked; write-back waits only if it is still stalled. Reset clears
// valid bits and reloads default windows; no clearing pass.
module live_entity_aging_table_unit #(
    parameter int ENTITIES = leat_pkg::ENTITIES_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              req_type,
    input  logic [63:0]       entity_key,
    input  logic              is_meta,
    input  logic              remote_id_source,
    input  logic signed [7:0] rssi,
    input  logic [47:0]       now_ms,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              accepted,
    output logic [3:0]        slot_used,
    output logic [31:0]       entry_count,
    output logic signed [7:0] peak_rssi,
    output logic [4:0]        active_count,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_idx,
    input  logic [31:0]       cfg_data
);
    import leat_pkg::*;

    leat_cmd_t  cmd;
    leat_stat_t stat;

    leat_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    leat_datapath #(.ENTITIES(ENTITIES)) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .cfg_we           (cfg_we),
        .cfg_idx          (cfg_idx),
        .cfg_data         (cfg_data),
        .req_type         (req_type),
        .entity_key       (entity_key),
        .is_meta          (is_meta),
        .remote_id_source (remote_id_source),
        .rssi             (rssi),
        .now_ms           (now_ms),
        .accepted         (accepted),
        .slot_used        (slot_used),
        .entry_count      (entry_count),
        .peak_rssi        (peak_rssi),
        .active_count     (active_count)
    );
endmodule

/* src/leat_datapath.sv */
// Datapath: slot storage, walk over the table, update and result word.
// Depends on leat_pkg.
module leat_datapath #(
    parameter int ENTITIES = leat_pkg::ENTITIES_DEFAULT,
    parameter int IDX_W    = (ENTITIES > 1) ? $clog2(ENTITIES) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  leat_pkg::leat_cmd_t          cmd,
    output leat_pkg::leat_stat_t         stat,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_idx,
    input  logic [31:0]                  cfg_data,
    input  logic                         req_type,
    input  logic [63:0]                  entity_key,
    input  logic                         is_meta,
    input  logic                         remote_id_source,
    input  logic signed [7:0]            rssi,
    input  logic [47:0]                  now_ms,
    output logic                         accepted,
    output logic [3:0]                   slot_used,
    output logic [31:0]                  entry_count,
    output logic signed [7:0]            peak_rssi,
    output logic [4:0]                   active_count
);
    import leat_pkg::*;

    localparam int CW = $clog2(ENTITIES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTITIES - 1);

    logic [WIN_W-1:0] meta_win_reg, rid_win_reg, ssid_win_reg;

    logic [ENTITIES-1:0]     valid_reg;
    logic [KEY_W-1:0]        key_mem   [ENTITIES];
    logic                    meta_mem  [ENTITIES];
    logic                    rid_mem   [ENTITIES];
    logic [TIME_W-1:0]       seen_mem  [ENTITIES];
    logic [CNT_W-1:0]        cnt_mem   [ENTITIES];
    logic signed [RSSI_W-1:0] best_mem [ENTITIES];

    logic                    req_reg, meta_in_reg, rid_in_reg;
    logic [KEY_W-1:0]        key_in_reg;
    logic signed [RSSI_W-1:0] rssi_in_reg;
    logic [TIME_W-1:0]       now_reg;

    logic [IDX_W-1:0] idx_reg;
    logic             found_reg, free_reg;
    logic [IDX_W-1:0] match_reg, free_idx_reg, old_reg;
    logic [TIME_W-1:0] old_seen_reg;
    logic [CW-1:0]    act_reg;

    logic                    s_valid, s_meta, s_rid, s_active, s_match;
    logic [TIME_W-1:0]       s_seen, s_age;
    logic [WIN_W-1:0]        s_win;

    assign s_valid = valid_reg[idx_reg];
    assign s_meta  = meta_mem[idx_reg];
    assign s_rid   = rid_mem[idx_reg];
    assign s_seen  = seen_mem[idx_reg];
    assign s_age   = now_reg - s_seen;
    assign s_win   = s_meta ? meta_win_reg : (s_rid ? rid_win_reg : ssid_win_reg);
    assign s_active = s_valid && ((now_reg < s_seen) || (s_age <= TIME_W'(s_win)));
    assign s_match = s_valid && (s_meta == meta_in_reg) && (key_mem[idx_reg] == key_in_reg);

    assign stat.last     = (idx_reg == LAST_IDX);

    // Final selection during finish.
    logic [IDX_W-1:0]        w_slot;
    logic                    w_restart;
    logic [CNT_W-1:0]        w_old, w_next;
    logic signed [RSSI_W-1:0] w_oldbest, w_best;

    always_comb
    begin
        if (found_reg)
        begin
            w_slot = match_reg;
        end
        else if (free_reg)
        begin
            w_slot = free_idx_reg;
        end
        else
        begin
            w_slot = old_reg;
        end
        w_restart = !found_reg || !s_active;
        w_old     = w_restart ? '0 : cnt_mem[w_slot];
        w_oldbest = w_restart ? rssi_in_reg : best_mem[w_slot];
        w_next    = (w_old == CNT_SAT) ? CNT_SAT : w_old + 1'b1;
        w_best    = ((w_old == '0) || (rssi_in_reg > w_oldbest)) ? rssi_in_reg : w_oldbest;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meta_win_reg <= 32'd60000;
            rid_win_reg  <= 32'd30000;
            ssid_win_reg <= 32'd30000;
            valid_reg    <= '0;
            idx_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    REG_META_WIN: meta_win_reg <= cfg_data;
                    REG_RID_WIN:  rid_win_reg  <= cfg_data;
                    REG_SSID_WIN: ssid_win_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.start)
            begin
                idx_reg <= '0;
            end
            else if (cmd.step)
            begin
                if (!stat.last)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                else if (!req_reg && found_reg)
                begin
                    idx_reg <= match_reg;
                end
            end
            if (cmd.finish && !req_reg)
            begin
                valid_reg[w_slot] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            req_reg      <= req_type;
            key_in_reg   <= entity_key;
            meta_in_reg  <= is_meta;
            rid_in_reg   <= remote_id_source;
            rssi_in_reg  <= rssi;
            now_reg      <= now_ms;
            found_reg    <= 1'b0;
            free_reg     <= 1'b0;
            old_reg      <= '0;
            act_reg      <= '0;
            match_reg    <= '0;
            free_idx_reg <= '0;
        end
        else if (cmd.step)
        begin
            if (s_active)
            begin
                act_reg <= act_reg + 1'b1;
            end
            if (s_match && !found_reg)
            begin
                found_reg <= 1'b1;
                match_reg <= idx_reg;
            end
            if (!s_valid && !free_reg)
            begin
                free_reg     <= 1'b1;
                free_idx_reg <= idx_reg;
            end
            if (s_valid && ((idx_reg == '0) || (s_seen < old_seen_reg)))
            begin
                old_reg      <= idx_reg;
                old_seen_reg <= s_seen;
            end
        end
        if (cmd.finish)
        begin
            accepted     <= !req_reg;
            slot_used    <= req_reg ? 4'd0 : SLOT_W'(32'(w_slot));
            entry_count  <= req_reg ? '0 : w_next;
            peak_rssi    <= req_reg ? '0 : w_best;
            active_count <= req_reg ? ACT_W'(32'(act_reg)) : '0;
            if (!req_reg)
            begin
                key_mem[w_slot]  <= key_in_reg;
                meta_mem[w_slot] <= meta_in_reg;
                rid_mem[w_slot]  <= rid_in_reg;
                seen_mem[w_slot] <= now_reg;
                cnt_mem[w_slot]  <= w_next;
                best_mem[w_slot] <= w_best;
            end
        end
    end
endmodule

/* src/leat_ctrl.sv */
// Controller: accepts a word, walks the table, presents the result word.
// Depends on leat_pkg.
module leat_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    output leat_pkg::leat_cmd_t  cmd,
    input  leat_pkg::leat_stat_t stat
);
    import leat_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       ov_reg, ov_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        ov_next    = ov_reg && out_stall;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                cmd.step = 1'b1;
                if (stat.last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!ov_reg || !out_stall)
                begin
                    cmd.finish = 1'b1;
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end
endmodule
